// ----- rtl/outlier_rejecting_range_filter_assert.svh -----
// ---------------------------------------------------------------------------
// Outlier-rejecting range filter: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef OUTLIER_REJECTING_RANGE_FILTER_ASSERT_SVH
`define OUTLIER_REJECTING_RANGE_FILTER_ASSERT_SVH

// Same-cycle implication.
`define ORF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ORF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/orf_pkg.sv -----
// ---------------------------------------------------------------------------
// Outlier-rejecting range filter package
// Field widths, register map, bank codes and shared structs.
// ---------------------------------------------------------------------------
package orf_pkg;

  localparam int DIST_W    = 16;
  localparam int ID_W      = 3;
  localparam int THR_W     = 16;
  localparam int LIM_W     = 4;
  localparam int CNT_W     = 4;
  localparam int NUM_BANKS = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(300);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // Register index (paddr[2])
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  typedef logic [1:0] bank_t;
  localparam bank_t BANK_A      = 2'd0;
  localparam bank_t BANK_B      = 2'd1;
  localparam bank_t BANK_C      = 2'd2;
  localparam bank_t BANK_BYPASS = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [LIM_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    bank_t            bank;
    logic             reload;
    logic [CNT_W-1:0] cnt;
  } upd_t;

  function automatic bank_t bank_of(input logic [ID_W-1:0] id);
    bank_t b;
    unique case (id[1:0])
      2'd0:    b = BANK_A;
      2'd1:    b = BANK_B;
      2'd3:    b = BANK_C;
      default: b = BANK_BYPASS;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/orf_cfg.sv -----
// ---------------------------------------------------------------------------
// Outlier-rejecting range filter: configuration registers
// APB-style register file for threshold and outlier limit.
// ---------------------------------------------------------------------------
module orf_cfg
  import orf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    thr_nxt = thr_r;
    lim_nxt = lim_r;
    if (wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_nxt = pwdata[THR_W-1:0];
        REG_LIMIT:     lim_nxt = pwdata[LIM_W-1:0];
        default:       thr_nxt = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      lim_r <= LIM_RESET;
    end else begin
      thr_r <= thr_nxt;
      lim_r <= lim_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = APB_DW'(thr_r);
      REG_LIMIT:     prdata = APB_DW'(lim_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold = thr_r;
  assign cfg.limit     = lim_r;

endmodule

// ----- rtl/orf_state.sv -----
// ---------------------------------------------------------------------------
// Outlier-rejecting range filter: bank state
// Per-bank sample windows and consecutive-outlier counts.
// ---------------------------------------------------------------------------
module orf_state
  import orf_pkg::*;
#(
  parameter int WINDOW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bank_t             rd_bank,
  output logic [DIST_W-1:0] rd_win [WINDOW],
  output logic [CNT_W-1:0]  rd_cnt,
  input  upd_t              upd,
  input  logic [DIST_W-1:0] upd_dist
);

  logic [DIST_W-1:0] win_r   [NUM_BANKS][WINDOW];
  logic [DIST_W-1:0] win_nxt [NUM_BANKS][WINDOW];
  logic [CNT_W-1:0]  cnt_r   [NUM_BANKS];
  logic [CNT_W-1:0]  cnt_nxt [NUM_BANKS];

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rd_win[i] = (rd_bank == BANK_BYPASS) ? '0 : win_r[rd_bank][i];
    end
    rd_cnt = (rd_bank == BANK_BYPASS) ? '0 : cnt_r[rd_bank];
  end

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (upd.wr_en && upd.bank != BANK_BYPASS) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (upd.reload || i == WINDOW - 1) begin
          win_nxt[upd.bank][i] = upd_dist;
        end else begin
          win_nxt[upd.bank][i] = win_r[upd.bank][i+1];
        end
      end
      cnt_nxt[upd.bank] = upd.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        cnt_r[b] <= '0;
        for (int i = 0; i < WINDOW; i++) begin
          win_r[b][i] <= '0;
        end
      end
    end else begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/orf_calc.sv -----
// ---------------------------------------------------------------------------
// Outlier-rejecting range filter: decision datapath
// Window sum, deviation test and next bank count for one item.
// ---------------------------------------------------------------------------
module orf_calc
  import orf_pkg::*;
#(
  parameter int WINDOW = 3
) (
  input  cfg_t              cfg,
  input  logic [ID_W-1:0]   sensor_id,
  input  logic [DIST_W-1:0] sample_mm,
  input  logic [DIST_W-1:0] win [WINDOW],
  input  logic [CNT_W-1:0]  cnt,
  output bank_t             bank,
  output logic [DIST_W-1:0] filtered_mm,
  output logic              was_outlier,
  output upd_t              upd
);

  localparam int SUM_W = DIST_W + $clog2(WINDOW);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] scaled;
  logic [SUM_W-1:0] lim;
  logic [SUM_W-1:0] dev;
  logic [CNT_W-1:0] cnt_inc;
  logic             bypass;
  logic             reload;

  assign bank   = bank_of(sensor_id);
  assign bypass = (bank == BANK_BYPASS);

  always_comb begin
    sum = SUM_W'(sample_mm);
    for (int i = 1; i < WINDOW; i++) begin
      sum = sum + SUM_W'(win[i]);
    end
  end

  assign scaled = SUM_W'(WINDOW) * SUM_W'(sample_mm);
  assign lim    = SUM_W'(WINDOW) * SUM_W'(cfg.threshold);
  assign dev    = (scaled >= sum) ? (scaled - sum) : (sum - scaled);

  assign was_outlier = !bypass && (dev > lim);
  assign cnt_inc     = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
  assign reload      = was_outlier && (cnt_inc > cfg.limit);
  assign filtered_mm = was_outlier ? win[1] : sample_mm;

  assign upd.wr_en  = !bypass;
  assign upd.bank   = bank;
  assign upd.reload = reload;
  assign upd.cnt    = (was_outlier && !reload) ? cnt_inc : '0;

endmodule

// ----- rtl/outlier_rejecting_range_filter.sv -----
// ---------------------------------------------------------------------------
// Outlier-rejecting range filter
// Per-bank window mean test with outlier rejection and window reload.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     in_sensor_id, in_distance_mm
//   out      source     out_valid / out_ready   out_filtered_mm, out_was_outlier
//   cfg      APB slave  psel/penable/pwrite     paddr, pwdata, prdata
//
// One item per cycle while results are taken; each result passes from the
// input register, which feeds the bank read/update, to the result register
// and the out ports; a bank update is seen by the very next item.
// Synchronous reset clears windows, counts, valid flags; config to defaults.
// A stalled result holds the input register; the input accepts again once
// the result register drains or is taken in the same cycle.
// ---------------------------------------------------------------------------
module outlier_rejecting_range_filter
  import orf_pkg::*;
#(
  parameter int WINDOW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   in_sensor_id,
  input  logic [DIST_W-1:0] in_distance_mm,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_filtered_mm,
  output logic              out_was_outlier,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

`include "outlier_rejecting_range_filter_assert.svh"

  cfg_t              cfg;
  logic              s1_valid_r, s1_valid_nxt;
  logic [ID_W-1:0]   s1_id_r;
  logic [DIST_W-1:0] s1_dist_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_filt_r;
  logic              out_outl_r;
  logic              advance;
  bank_t             bank;
  logic [DIST_W-1:0] win [WINDOW];
  logic [CNT_W-1:0]  cnt;
  logic [DIST_W-1:0] filt;
  logic              outl;
  upd_t              upd_calc;
  upd_t              upd;

  orf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  orf_state #(.WINDOW(WINDOW)) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_bank  (bank),
    .rd_win   (win),
    .rd_cnt   (cnt),
    .upd      (upd),
    .upd_dist (s1_dist_r)
  );

  orf_calc #(.WINDOW(WINDOW)) u_calc (
    .cfg         (cfg),
    .sensor_id   (s1_id_r),
    .sample_mm   (s1_dist_r),
    .win         (win),
    .cnt         (cnt),
    .bank        (bank),
    .filtered_mm (filt),
    .was_outlier (outl),
    .upd         (upd_calc)
  );

  assign advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    upd       = upd_calc;
    upd.wr_en = upd_calc.wr_en && advance;
  end

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_id_r   <= in_sensor_id;
      s1_dist_r <= in_distance_mm;
    end
    if (advance) begin
      out_filt_r <= filt;
      out_outl_r <= outl;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_filtered_mm = out_filt_r;
  assign out_was_outlier = out_outl_r;

  `ORF_ASSERT_IMP(a_ready_when_free, clk, rst_n, (!out_valid_r || out_ready), in_ready,
                  "input stalled while result path free")
  `ORF_ASSERT_NXT(a_advance_gives_result, clk, rst_n, advance, out_valid,
                  "advanced item produced no result")
  `ORF_ASSERT_NXT(a_bypass_passes, clk, rst_n, (advance && bank == BANK_BYPASS),
                  (!out_was_outlier && out_filtered_mm == $past(s1_dist_r)),
                  "bypass item altered")

endmodule
